FILE: rtl/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg: shared types and constants of the compass heading block
// Data widths, the CORDIC word passed along the cell chain, and the
// arctangent table in units of 1/65536 of a hundredth of a degree.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TAB_LEN           = 24;

  // Axis datapath: 17-bit magnitude scaled by 256, plus CORDIC growth.
  localparam int XY_W = 27;
  // Angle accumulator, 1/65536 centidegree.
  localparam int Z_W  = 32;
  // Rounded heading before the final wrap, centidegrees.
  localparam int Q_W  = 18;
  localparam int HEAD_W = 16;

  localparam int PRE_SHIFT = 8;
  localparam int ANG_SHIFT = 16;

  localparam logic signed [Z_W-1:0] HALF_TURN_Z = 32'sd1179648000;
  localparam logic signed [Q_W-1:0] FULL_TURN   = 18'sd36000;

  typedef struct packed {
    logic                   vld;
    logic                   zero;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_word_t;

  function automatic logic signed [Z_W-1:0] atan_lut(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:       v = 32'sd294912000;
      1:       v = 32'sd174096719;
      2:       v = 32'sd91987925;
      3:       v = 32'sd46694507;
      4:       v = 32'sd23437865;
      5:       v = 32'sd11730458;
      6:       v = 32'sd5866610;
      7:       v = 32'sd2933484;
      8:       v = 32'sd1466764;
      9:       v = 32'sd733385;
      10:      v = 32'sd366693;
      11:      v = 32'sd183346;
      12:      v = 32'sd91673;
      13:      v = 32'sd45837;
      14:      v = 32'sd22918;
      15:      v = 32'sd11459;
      16:      v = 32'sd5730;
      17:      v = 32'sd2865;
      18:      v = 32'sd1432;
      19:      v = 32'sd716;
      20:      v = 32'sd358;
      21:      v = 32'sd179;
      22:      v = 32'sd90;
      23:      v = 32'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/chs_prep.sv
// ----------------------------------------------------------------------------
// chs_prep: input conditioning cell
// Folds the left half plane onto the right one, scales the axes by 256 and
// flags the all-zero vector.
// ----------------------------------------------------------------------------
module chs_prep (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [15:0]         mag_x,
  input  logic signed [15:0]         mag_y,
  output chs_pkg::cordic_word_t      word_out
);
  import chs_pkg::*;

  logic                   neg;
  logic signed [XY_W-1:0] xe;
  logic signed [XY_W-1:0] ye;
  logic signed [XY_W-1:0] xf;
  logic signed [XY_W-1:0] yf;

  assign neg = mag_x[15];
  assign xe  = XY_W'(mag_x);
  assign ye  = XY_W'(mag_y);
  assign xf  = neg ? -xe : xe;
  assign yf  = neg ? -ye : ye;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_out.vld <= 1'b0;
    end else begin
      word_out.vld <= start;
    end
    word_out.zero <= (mag_x == 16'sd0) && (mag_y == 16'sd0);
    word_out.x    <= xf <<< PRE_SHIFT;
    word_out.y    <= yf <<< PRE_SHIFT;
    word_out.z    <= neg ? HALF_TURN_Z : '0;
  end

endmodule

FILE: rtl/chs_cell.sv
// ----------------------------------------------------------------------------
// chs_cell: one CORDIC vectoring cell
// Rotates the vector toward the X axis by atan(2^-SHIFT) and updates the
// angle accumulator; shifts round toward minus infinity.
// ----------------------------------------------------------------------------
module chs_cell #(
  parameter int SHIFT = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  chs_pkg::cordic_word_t word_in,
  output chs_pkg::cordic_word_t word_out
);
  import chs_pkg::*;

  localparam logic signed [Z_W-1:0] ANGLE = atan_lut(SHIFT);

  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic                   up;

  assign x  = word_in.x;
  assign y  = word_in.y;
  assign dx = y >>> SHIFT;
  assign dy = x >>> SHIFT;
  assign up = ~y[XY_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      word_out.vld <= 1'b0;
    end else begin
      word_out.vld <= word_in.vld;
    end
    word_out.zero <= word_in.zero;
    word_out.x    <= up ? x + dx : x - dx;
    word_out.y    <= up ? y - dy : y + dy;
    word_out.z    <= up ? word_in.z + ANGLE : word_in.z - ANGLE;
  end

endmodule

FILE: rtl/chs_wrap.sv
// ----------------------------------------------------------------------------
// chs_wrap: declination, rounding and wrap into one turn
// First stage adds the declination and rounds to centidegrees; second stage
// reduces the result into 0 to 35999.
// ----------------------------------------------------------------------------
module chs_wrap (
  input  logic                  clk,
  input  logic                  rst,
  input  chs_pkg::cordic_word_t word_in,
  input  logic signed [15:0]    decl,
  output logic                  done,
  output logic [15:0]           heading
);
  import chs_pkg::*;

  localparam int T_W = Q_W + ANG_SHIFT;

  logic signed [T_W-1:0] total;
  logic signed [Z_W-1:0] z_eff;
  logic                  q_vld;
  logic signed [Q_W-1:0] q;
  logic signed [Q_W-1:0] q_up;
  logic signed [Q_W-1:0] q_up2;
  logic signed [Q_W-1:0] q_dn;
  logic signed [Q_W-1:0] r;

  assign z_eff = word_in.zero ? '0 : word_in.z;
  assign total = T_W'(z_eff) + (T_W'(decl) <<< ANG_SHIFT)
               + (T_W'(1) <<< (ANG_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
    end else begin
      q_vld <= word_in.vld;
    end
    q <= total[T_W-1:ANG_SHIFT];
  end

  assign q_up  = q + FULL_TURN;
  assign q_up2 = q_up + FULL_TURN;
  assign q_dn  = q - FULL_TURN;

  always_comb begin
    if (q < 0) begin
      r = (q_up < 0) ? q_up2 : q_up;
    end else if (q >= FULL_TURN) begin
      r = q_dn;
    end else begin
      r = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_vld;
    end
    heading <= r[HEAD_W-1:0];
  end

endmodule

FILE: rtl/compass_heading_atan2.sv
// ----------------------------------------------------------------------------
// compass_heading_atan2: magnetometer compass heading
// Pipelined CORDIC atan2 of one X/Y sample pair plus a programmable
// declination, giving the heading in hundredths of a degree.
// ----------------------------------------------------------------------------
// A sample word is taken at every clock edge where start is high; busy is
// always low, so a new pair may be offered in every cycle. The pair runs
// through one conditioning cell, CORDIC_STAGES rotation cells and two wrap
// stages, and its heading appears on heading_centideg from the second wrap
// stage, marked by a one-cycle done pulse. Words leave in the order they
// came in, one per cycle at most, and the receiver must take each word in
// the cycle it is shown since there is no way to hold it. The heading is
// atan2(mag_y, mag_x) plus the declination, rounded to the nearest
// hundredth of a degree and wrapped into 0 to 35999; an all-zero sample
// gives the declination alone. The declination is written through cfg_wen
// and cfg_wdata and should only change while no sample is in flight; it
// resets to zero.
// ----------------------------------------------------------------------------
module compass_heading_atan2 #(
  parameter int CORDIC_STAGES = chs_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] mag_x,
  input  logic signed [15:0] mag_y,
  input  logic               cfg_wen,
  input  logic signed [15:0] cfg_wdata,
  output logic               done,
  output logic [15:0]        heading_centideg
);
  import chs_pkg::*;

  localparam int LATENCY = CORDIC_STAGES + 3;

  // Declination register, centidegrees.
  logic signed [15:0] decl;

  // Word handed from cell to cell; entry 0 comes from the conditioning cell.
  cordic_word_t chain [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      decl <= '0;
    end else if (cfg_wen) begin
      decl <= cfg_wdata;
    end
  end

  // The pipeline takes a word every cycle, so it never pushes back.
  assign busy = 1'b0;

  chs_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .mag_x    (mag_x),
    .mag_y    (mag_y),
    .word_out (chain[0])
  );

  // One rotation cell per CORDIC iteration; cell g shifts by g bits.
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    chs_cell #(
      .SHIFT (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .word_in  (chain[g]),
      .word_out (chain[g+1])
    );
  end

  chs_wrap u_wrap (
    .clk     (clk),
    .rst     (rst),
    .word_in (chain[CORDIC_STAGES]),
    .decl    (decl),
    .done    (done),
    .heading (heading_centideg)
  );

`ifndef SYNTH
  // Every heading word stems from a sample taken a fixed latency earlier.
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("heading word without a matching sample");

  // The wrap stage always lands inside one turn.
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (heading_centideg < 16'd36000))
    else $error("heading outside 0 to 35999");

  // A zero vector with zero declination must read as north.
  a_zero_vector: assert property (@(posedge clk) disable iff (rst)
    (done && (decl == 16'sd0) &&
     $past(start && (mag_x == 16'sd0) && (mag_y == 16'sd0), LATENCY))
    |-> (heading_centideg == 16'd0))
    else $error("zero vector did not give zero heading");
`endif

endmodule

FILE: tb/compass_heading_checker.sv
// ----------------------------------------------------------------------------
// compass_heading_checker: heading predictor and scoreboard
// Watches the sample, configuration and result channels of the compass
// heading block. It predicts each heading with its own CORDIC and compares
// the results in order.
// ----------------------------------------------------------------------------
module compass_heading_checker #(
  parameter int STAGES = chs_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] mag_x,
  input  logic signed [15:0] mag_y,
  input  logic               cfg_wen,
  input  logic signed [15:0] cfg_wdata,
  input  logic               done,
  input  logic [15:0]        heading_centideg,
  output int                 fail_count,
  output int                 in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  // atan(2^-i) in units of 1/65536 centidegree, rounded to nearest.
  localparam longint ATAN_STEP [24] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730458,
    5866610, 2933484, 1466764, 733385, 366693, 183346,
    91673, 45837, 22918, 11459, 5730, 2865,
    1432, 716, 358, 179, 90, 45
  };

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] decl;
    logic [15:0]        heading;
  } heading_due_t;

  heading_due_t       headings_due[$];
  logic signed [15:0] declination;

  initial begin
    fail_count = 0;
    in_flight  = 0;
    declination = '0;
  end

  // Vectoring CORDIC on the axes scaled by 256; arithmetic right shifts on
  // longint round toward minus infinity, as the hardware cells do.
  function automatic logic [15:0] heading_of(input logic signed [15:0] mx,
                                              input logic signed [15:0] my,
                                              input logic signed [15:0] decl);
    longint x, y, z, dx, dy, total, q, r;
    x = mx;
    y = my;
    z = 0;
    if (x != 0 || y != 0) begin
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 64'sd18000 * 64'sd65536;
      end
      x = x * 256;
      y = y * 256;
      for (int i = 0; i < STAGES && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_STEP[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_STEP[i];
        end
      end
    end
    total = z + longint'(decl) * 65536 + 32768;
    q = total >>> 16;
    r = q % 36000;
    if (r < 0) r = r + 36000;
    return r[15:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns heading check: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    heading_due_t want;
    if (rst) begin
      declination = '0;
      headings_due.delete();
    end else begin
      // Each result leaves after its word was pushed, so retire before pushing.
      if (done) begin
        if (headings_due.size() == 0) begin
          report_mismatch($sformatf("heading %0d arrived with no word pending",
                                    heading_centideg));
        end else begin
          want = headings_due.pop_front();
          if (heading_centideg !== want.heading)
            report_mismatch($sformatf(
              "x=%0d y=%0d decl=%0d: heading %0d, predicted %0d",
              want.x, want.y, want.decl, heading_centideg, want.heading));
        end
      end
      if (start && !busy) begin
        want.x       = mag_x;
        want.y       = mag_y;
        want.decl    = declination;
        want.heading = heading_of(mag_x, mag_y, declination);
        headings_due.push_back(want);
      end
      if (cfg_wen) declination = cfg_wdata;
    end
    in_flight <= headings_due.size();
  end

endmodule

FILE: tb/tb_compass_heading_atan2.sv
// ----------------------------------------------------------------------------
// tb_compass_heading_atan2: testbench of the compass heading block
// Drives directed and random magnetometer pairs in bursts under several
// declination settings; a separate checker predicts every heading and
// counts mismatches, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_compass_heading_atan2;
  timeunit 1ns;
  timeprecision 1ps;

  // Pipeline depth of the block from start to done, used for the final wait.
  localparam int LATENCY      = chs_pkg::CORDIC_STAGES_DEF + 3;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_PAIRS = 552;
  localparam int PHASES       = 8;
  localparam int DIRECTED_N   = 22;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] mag_x = '0;
  logic signed [15:0] mag_y = '0;
  logic               cfg_wen = 1'b0;
  logic signed [15:0] cfg_wdata = '0;
  logic               done;
  logic [15:0]        heading_centideg;
  int                 fail_count;
  int                 in_flight;
  int                 cycles = 0;

  // Directed pairs: every axis extreme, all four diagonal corners, unit
  // vectors around the origin, the all-zero pair, two pairs just below the
  // positive X axis (one rounds up to 360 and wraps to zero, one stays at
  // 359.99), and pairs on either side of the negative X axis where the
  // half-turn pre-rotation kicks in.
  logic signed [15:0] dir_x [DIRECTED_N] = '{
    0, 32767, -32768, 0, 0, 32767, -32768, -32768, 32767, -1, 1,
    0, 0, -1, 1, -1, 32767, 32767, -1000, -1000, -32768, 12345
  };
  logic signed [15:0] dir_y [DIRECTED_N] = '{
    0, 0, 0, 32767, -32768, 32767, -32768, 32767, -32768, 0, 0,
    1, -1, -1, -1, 1, -1, -3, 5, -5, -1, -23456
  };

  // Declination plan, one setting per random phase: both range ends, then
  // the 16-bit extremes (outside the nominal range, relying on the modulo
  // wrap), a random one, an explicit return to zero and two random ones.
  logic signed [15:0] decl_plan [PHASES] = '{
    18000, -18000, 32767, -32768, 0, 0, 0, 0
  };
  bit decl_is_random [PHASES] = '{0, 0, 0, 0, 1, 0, 1, 1};

  logic signed [15:0] corner [5] = '{-32768, -1, 0, 1, 32767};

  compass_heading_atan2 i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .mag_x            (mag_x),
    .mag_y            (mag_y),
    .cfg_wen          (cfg_wen),
    .cfg_wdata        (cfg_wdata),
    .done             (done),
    .heading_centideg (heading_centideg)
  );

  compass_heading_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .mag_x            (mag_x),
    .mag_y            (mag_y),
    .cfg_wen          (cfg_wen),
    .cfg_wdata        (cfg_wdata),
    .done             (done),
    .heading_centideg (heading_centideg),
    .fail_count       (fail_count),
    .in_flight        (in_flight)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Offers one word and returns at the edge that takes it. Start is left
  // high so that the next word of a burst follows without a gap.
  task automatic send_pair(input logic signed [15:0] x,
                           input logic signed [15:0] y);
    start <= 1'b1;
    mag_x <= x;
    mag_y <= y;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drops start for the given number of cycles (at least one).
  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stops offering words and waits until every heading has come back. The
  // count from the checker is registered and trails the queue, so it is read
  // only after the pause that follows the last possible acceptance.
  task automatic wait_drained();
    pause(1);
    do @(posedge clk); while (in_flight != 0);
  endtask

  // The declination only changes with the pipeline empty.
  task automatic write_declination(input logic signed [15:0] v);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  initial begin
    int                 left;
    int                 burst;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] decl;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed words run at the reset declination of zero, back to back
    // apart from one short gap in the middle.
    for (int i = 0; i < DIRECTED_N; i++) begin
      send_pair(dir_x[i], dir_y[i]);
      if (i == DIRECTED_N / 2) pause(2);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      decl = decl_plan[ph];
      if (decl_is_random[ph]) decl = 16'(int'($urandom_range(0, 36000)) - 18000);
      write_declination(decl);

      left = RANDOM_PAIRS / PHASES;
      while (left > 0) begin
        // Mostly short bursts, now and then a long one with no idle cycle.
        burst = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
        while (burst > 0 && left > 0) begin
          // Half of the pairs are fully random, so every input bit toggles;
          // the rest aim at the origin, the axes, the corners, and the
          // neighborhoods of 0/360 and 180 degrees where rounding and the
          // half-turn pre-rotation matter.
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
              x = 16'($urandom);
              y = 16'($urandom);
            end
            5: begin
              x = 16'(int'($urandom_range(0, 8)) - 4);
              y = 16'(int'($urandom_range(0, 8)) - 4);
            end
            6: begin
              if ($urandom_range(0, 1) == 1) begin
                x = '0;
                y = 16'($urandom);
              end else begin
                x = 16'($urandom);
                y = '0;
              end
            end
            7: begin
              x = corner[$urandom_range(0, 4)];
              y = corner[$urandom_range(0, 4)];
            end
            8: begin
              x = 16'(-int'($urandom_range(1, 32768)));
              y = 16'(int'($urandom_range(0, 8)) - 4);
            end
            default: begin
              x = 16'($urandom_range(1, 32767));
              y = 16'(int'($urandom_range(0, 8)) - 4);
            end
          endcase
          send_pair(x, y);
          left--;
          burst--;
          // Once in the run, hold off mid-phase until the pipeline empties.
          if (ph == 2 && left == 30) wait_drained();
        end
        pause($urandom_range(1, 6));
      end
    end

    wait_drained();
    repeat (LATENCY + 4) @(posedge clk);
    if (fail_count == 0 && in_flight == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/chs_pkg.sv
rtl/chs_prep.sv
rtl/chs_cell.sv
rtl/chs_wrap.sv
rtl/compass_heading_atan2.sv
tb/compass_heading_checker.sv
tb/tb_compass_heading_atan2.sv
